### src/lru_record_cache_macros.svh
// assertion macros shared by the checker of lru_record_cache
// expects signals named clock and reset in the scope of use
`ifndef LRU_RECORD_CACHE_MACROS_SVH
`define LRU_RECORD_CACHE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lrc_pkg.sv
// types and constants of the lru record cache
// used by the cells, the remainder unit, the top level and the checker
package lrc_pkg;

   // wide enough to index up to 1024 slots
   localparam int SLOT_IDX_W = 10;
   localparam int ID_W       = 64;
   localparam int CAP_REG_W  = 7;
   localparam int WORKER_W   = 5;
   localparam int QUEUE_W    = 4;
   localparam int SLOT_OUT_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [WORKER_W-1:0]    MAX_WORKERS   = 5'd16;
   localparam logic [CAP_REG_W-1:0]   CAP_RESET     = 7'd64;
   localparam logic [WORKER_W-1:0]    WORKER_RESET  = 5'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORKERS  = 2'd1;

   typedef enum logic [2:0] {
      STATUS_HIT           = 3'd0,
      STATUS_MISS_FETCH    = 3'd1,
      STATUS_MISS_NOFETCH  = 3'd2,
      STATUS_FILL_FREE     = 3'd3,
      STATUS_FILL_EVICT    = 3'd4,
      STATUS_FILL_RESIDENT = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_PROMOTE,
      CMD_FILL,
      CMD_EVICT
   } cmd_type;

   typedef struct packed {
      logic                  action;
      logic [ID_W-1:0]       record_id;
      logic [ID_W-1:0]       request_token;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [ID_W-1:0]       fetch_token;
      logic [QUEUE_W-1:0]    queue_index;
      logic [ID_W-1:0]       evicted_id;
   } rsp_type;

   // partial search result walking down the cell chain
   typedef struct packed {
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_slot;
      logic [SLOT_IDX_W-1:0] hit_rank;
      logic                  free;
      logic [SLOT_IDX_W-1:0] free_slot;
      logic                  any;
      logic [SLOT_IDX_W-1:0] lru_slot;
      logic [SLOT_IDX_W-1:0] lru_rank;
      logic [ID_W-1:0]       lru_id;
   } scan_type;

   // update broadcast to every cell at the end of a search
   typedef struct packed {
      cmd_type               op;
      logic [SLOT_IDX_W-1:0] slot;
      logic [SLOT_IDX_W-1:0] rank;
   } commit_type;

endpackage

### src/lrc_cell.sv
// one slot of the lru record cache: id, valid bit and recency rank
// folds its entry into the search token from its neighbour; uses lrc_pkg
module lrc_cell import lrc_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [ID_W-1:0] key,
   input  commit_type      commit,
   input  scan_type        scan_in,
   output scan_type        scan_out
);

   localparam logic [SLOT_IDX_W-1:0] SELF = SLOT_IDX_W'(INDEX);

   logic                  valid_ff, valid_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [SLOT_IDX_W-1:0] rank_ff, rank_in;
   scan_type              scan_ff, scan_in_next;

   always_comb begin
      scan_in_next = scan_in;
      if (valid_ff && id_ff == key && !scan_in.hit) begin
         scan_in_next.hit      = 1'b1;
         scan_in_next.hit_slot = SELF;
         scan_in_next.hit_rank = rank_ff;
      end
      if (!valid_ff && !scan_in.free) begin
         scan_in_next.free      = 1'b1;
         scan_in_next.free_slot = SELF;
      end
      // strictly older wins, so the earlier slot keeps a tie
      if (valid_ff && (!scan_in.any || rank_ff > scan_in.lru_rank)) begin
         scan_in_next.any      = 1'b1;
         scan_in_next.lru_slot = SELF;
         scan_in_next.lru_rank = rank_ff;
         scan_in_next.lru_id   = id_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      rank_in  = rank_ff;
      case (commit.op)
         CMD_PROMOTE, CMD_EVICT: begin
            if (commit.slot == SELF) begin
               rank_in = '0;
               if (commit.op == CMD_EVICT) begin
                  id_in = key;
               end
            end else if (valid_ff && rank_ff < commit.rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         CMD_FILL: begin
            if (commit.slot == SELF) begin
               valid_in = 1'b1;
               id_in    = key;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      scan_ff <= scan_in_next;
   end

   assign scan_out = scan_ff;

endmodule

### src/lrc_qmod.sv
// remainder of a 64-bit id by the worker count, four id bits per clock
// 16 steps then a done pulse; uses lrc_pkg
module lrc_qmod import lrc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ID_W-1:0]     dividend,
   input  logic [WORKER_W-1:0] divisor,
   output logic                done,
   output logic [QUEUE_W-1:0]  remainder
);

   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = ID_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [ID_W-1:0]     shift_ff, shift_in;
   logic [QUEUE_W-1:0]  rem_ff, rem_in;
   logic [WORKER_W-1:0] div_ff, div_in;
   logic [QUEUE_W-1:0]  rem_step;

   // divisor is at most 16 so the partial remainder stays in 4 bits
   always_comb begin
      logic [QUEUE_W:0] t;
      rem_step = rem_ff;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         t = {rem_step, shift_ff[ID_W-1-j]};
         if (t >= div_ff) begin
            rem_step = QUEUE_W'(t - div_ff);
         end else begin
            rem_step = t[QUEUE_W-1:0];
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = shift_ff << BITS_PER_STEP;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### src/lru_record_cache.sv
// Fully associative cache of 64-bit record ids in least-recently-used order, built as a
// chain of CAPACITY cells, one per slot. An accepted request is held while a search token
// walks down the chain one cell per clock, collecting the hit slot, the lowest free slot
// and the least recent entry; the COMMIT state applies the promotion, fill or eviction to
// every cell at once. A request passes through the SCAN, COMMIT and FINISH states before
// the next is accepted; a miss that fetches and a fill that evicts also wait in DIVIDE for
// the remainder unit that forms the queue index four id bits per clock. The result sits in
// an output register, so a new request is taken while it waits to be collected.
// Configuration writes are always accepted and must only be issued while the cache is idle.
// Depends on lrc_pkg, lrc_cell and lrc_qmod.
module lru_record_cache import lrc_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W  = $clog2(CAPACITY);
   localparam int USED_W = $clog2(CAPACITY + 1);
   localparam int EFF_W  = (USED_W > CAP_REG_W) ? USED_W : CAP_REG_W;

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      COMMIT,
      DIVIDE,
      FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   req_type              req_ff, req_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [CAP_REG_W-1:0] cap_ff, cap_in;
   logic [WORKER_W-1:0]  wrk_ff, wrk_in;
   logic [USED_W-1:0]    used_ff, used_in;

   scan_type             scan_link [0:CAPACITY];
   scan_type             fin;
   commit_type           commit;
   logic [EFF_W-1:0]     eff_cap;
   logic [WORKER_W-1:0]  eff_workers;
   logic                 mod_start;
   logic [ID_W-1:0]      mod_id;
   logic                 mod_done;
   logic [QUEUE_W-1:0]   mod_rem;

   assign scan_link[0] = '0;
   assign fin          = scan_link[CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      lrc_cell #(.INDEX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .key      (req_ff.record_id),
         .commit   (commit),
         .scan_in  (scan_link[g]),
         .scan_out (scan_link[g+1])
      );
   end

   lrc_qmod u_qmod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_id),
      .divisor   (eff_workers),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // zero capacity or workers count as one; larger values clamp to the slot count or 16
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = EFF_W'(1);
      end else if (EFF_W'(cap_ff) > EFF_W'(CAPACITY)) begin
         eff_cap = EFF_W'(CAPACITY);
      end else begin
         eff_cap = EFF_W'(cap_ff);
      end
      if (wrk_ff == '0) begin
         eff_workers = WORKER_W'(1);
      end else if (wrk_ff > MAX_WORKERS) begin
         eff_workers = MAX_WORKERS;
      end else begin
         eff_workers = wrk_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      used_in      = used_ff;
      cap_in       = cap_ff;
      wrk_in       = wrk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      commit.op    = CMD_NONE;
      commit.slot  = fin.hit_slot;
      commit.rank  = fin.hit_rank;
      mod_start    = 1'b0;
      mod_id       = req_ff.record_id;

      if (csr_valid) begin
         case (csr_index)
            CSR_CAPACITY: cap_in = csr_wdata[CAP_REG_W-1:0];
            CSR_WORKERS:  wrk_in = csr_wdata[WORKER_W-1:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               cnt_in   = '0;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CAPACITY - 1)) begin
               state_in = COMMIT;
            end
         end
         COMMIT: begin
            res_in             = '0;
            res_in.status      = STATUS_MISS_NOFETCH;
            if (fin.hit) begin
               commit.op     = CMD_PROMOTE;
               res_in.status = req_ff.action ? STATUS_FILL_RESIDENT : STATUS_HIT;
               res_in.slot   = SLOT_OUT_W'(fin.hit_slot);
            end else if (!req_ff.action) begin
               if (req_ff.request_token != '0) begin
                  res_in.status      = STATUS_MISS_FETCH;
                  res_in.fetch_token = req_ff.request_token;
                  mod_start          = 1'b1;
               end
            end else if (EFF_W'(used_ff) < eff_cap) begin
               commit.op     = CMD_FILL;
               commit.slot   = fin.free_slot;
               used_in       = used_ff + 1'b1;
               res_in.status = STATUS_FILL_FREE;
               res_in.slot   = SLOT_OUT_W'(fin.free_slot);
            end else begin
               commit.op         = CMD_EVICT;
               commit.slot       = fin.lru_slot;
               commit.rank       = fin.lru_rank;
               mod_id            = fin.lru_id;
               mod_start         = 1'b1;
               res_in.status     = STATUS_FILL_EVICT;
               res_in.slot       = SLOT_OUT_W'(fin.lru_slot);
               res_in.evicted_id = fin.lru_id;
            end
            state_in = mod_start ? DIVIDE : FINISH;
         end
         DIVIDE: begin
            if (mod_done) begin
               res_in.queue_index = mod_rem;
               state_in           = FINISH;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         used_ff      <= '0;
         cap_ff       <= CAP_RESET;
         wrk_ff       <= WORKER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         cap_ff       <= cap_in;
         wrk_ff       <= wrk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

### src/lrc_checker.sv
// port-level checks of lru_record_cache, attached by bind
// uses lrc_pkg and lru_record_cache_macros.svh
`include "lru_record_cache_macros.svh"

module lrc_checker import lrc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // transactions taken in but not yet collected
   logic [1:0] pending_ff, pending_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `LRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
   `LRC_ASSERT_NOW(a_rsp_has_req, rsp_valid, pending_ff != 2'd0, "response with no request outstanding")
   `LRC_ASSERT_NOW(a_req_bounded, req_fire, pending_ff < 2'd2, "request taken with two transactions outstanding")
   `LRC_ASSERT_NOW(a_evict_clean, rsp_valid && rsp_data.status != STATUS_FILL_EVICT, rsp_data.evicted_id == '0, "evicted id set without an eviction")
   `LRC_ASSERT_NOW(a_miss_slot, rsp_valid && (rsp_data.status == STATUS_MISS_FETCH || rsp_data.status == STATUS_MISS_NOFETCH), rsp_data.slot == '0, "miss reports a nonzero slot")

endmodule

bind lru_record_cache lrc_checker u_lrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
